/* rtl/core/pspar_pkg.sv */
// Shared types and constants for the particle sensor frame parser.
// No dependencies; every other file in rtl/core imports this package.
package pspar_pkg;

  // Default frame length in bytes, header and trailer included.
  localparam int PSPAR_FRAME_LEN = 32;

  // Header bytes and the sum of the two, which seeds the frame checksum.
  localparam logic [7:0]  PSPAR_HDR_FIRST  = 8'h42;
  localparam logic [7:0]  PSPAR_HDR_SECOND = 8'h4D;
  localparam logic [15:0] PSPAR_HDR_SUM    = 16'h008F;

  // Frame byte positions of the three readings (big-endian pairs).
  localparam int PSPAR_PM_FIRST_IDX = 10;
  localparam int PSPAR_PM_LAST_IDX  = 15;
  localparam int PSPAR_BODY_START   = 2;

  typedef enum logic {
    ACT_BYTE    = 1'b0,
    ACT_TIMEOUT = 1'b1
  } pspar_action_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_CSUM_ERR  = 2'd1,
    ST_TIMEOUT   = 2'd2,
    ST_NO_HEADER = 2'd3
  } pspar_status_t;

  typedef enum logic [1:0] {
    PH_HUNT  = 2'd0,
    PH_GOT42 = 2'd1,
    PH_BODY  = 2'd2
  } pspar_phase_t;

  // Result of processing one word, from the parser core to the top level.
  typedef struct packed {
    logic          has_result;
    pspar_status_t status;
    logic [15:0]   pm1_value;
    logic [15:0]   pm25_value;
    logic [15:0]   pm10_value;
  } pspar_result_t;

endpackage

/* rtl/core/pspar_in_if.sv */
// Input channel: one received byte or a receive timeout per word.
// Depends on pspar_pkg.
interface pspar_in_if
  import pspar_pkg::*;
  ();
  logic          valid;
  logic          ready;
  pspar_action_t action;
  logic [7:0]    rx_byte;

  modport source (output valid, output action, output rx_byte, input ready);
  modport sink   (input valid, input action, input rx_byte, output ready);
endinterface

/* rtl/core/pspar_out_if.sv */
// Result channel: status and the three readings per word.
// Depends on pspar_pkg.
interface pspar_out_if
  import pspar_pkg::*;
  ();
  logic          valid;
  logic          ready;
  pspar_status_t status;
  logic [15:0]   pm1_value;
  logic [15:0]   pm25_value;
  logic [15:0]   pm10_value;

  modport source (output valid, output status, output pm1_value, output pm25_value,
                  output pm10_value, input ready);
  modport sink   (input valid, input status, input pm1_value, input pm25_value,
                  input pm10_value, output ready);
endinterface

/* rtl/core/pspar_core.sv */
// Parser state and per-word next-state logic: header hunt, body collection, checksum.
// Depends on pspar_pkg.
module pspar_core
  import pspar_pkg::*;
#(
  parameter int FRAME_LEN = PSPAR_FRAME_LEN
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  pspar_action_t action,
  input  logic [7:0]    rx_byte,
  output pspar_result_t res
);

  localparam int IDX_W = $clog2(FRAME_LEN);
  localparam int HC_W  = $clog2(2 * FRAME_LEN + 1);
  localparam logic [IDX_W-1:0] IDX_TRAIL_HI = IDX_W'(FRAME_LEN - 2);
  localparam logic [IDX_W-1:0] IDX_PM_FIRST = IDX_W'(PSPAR_PM_FIRST_IDX);
  localparam logic [IDX_W-1:0] IDX_PM_LAST  = IDX_W'(PSPAR_PM_LAST_IDX);
  localparam logic [IDX_W-1:0] IDX_START    = IDX_W'(PSPAR_BODY_START);
  localparam logic [HC_W-1:0]  HUNT_LIMIT   = HC_W'(2 * FRAME_LEN);

  pspar_phase_t     phase_r, phase_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [HC_W-1:0]  hc_r, hc_nxt;
  logic [15:0]      sum_r, sum_nxt;
  logic [7:0]       trl_hi_r, trl_hi_nxt;
  logic [15:0]      pm_r   [3];
  logic [15:0]      pm_nxt [3];

  logic [HC_W-1:0]  hc_inc;
  logic [IDX_W-1:0] pm_off;
  logic [1:0]       pm_sel;

  assign hc_inc = hc_r + HC_W'(1);
  assign pm_off = idx_r - IDX_PM_FIRST;
  assign pm_sel = pm_off[2:1];

  always_comb begin
    phase_nxt  = phase_r;
    idx_nxt    = idx_r;
    hc_nxt     = hc_r;
    sum_nxt    = sum_r;
    trl_hi_nxt = trl_hi_r;
    pm_nxt     = pm_r;
    res        = '{has_result: 1'b0, status: ST_OK, default: '0};

    if (en) begin
      case (phase_r)
        PH_BODY: begin
          if (action == ACT_TIMEOUT) begin
            phase_nxt      = PH_HUNT;
            hc_nxt         = '0;
            idx_nxt        = '0;
            sum_nxt        = '0;
            res.has_result = 1'b1;
            res.status     = ST_TIMEOUT;
          end else if (idx_r < IDX_TRAIL_HI) begin
            sum_nxt = sum_r + {8'd0, rx_byte};
            if (idx_r >= IDX_PM_FIRST && idx_r <= IDX_PM_LAST) begin
              pm_nxt[pm_sel] = {pm_r[pm_sel][7:0], rx_byte};
            end
            idx_nxt = idx_r + IDX_W'(1);
          end else if (idx_r == IDX_TRAIL_HI) begin
            trl_hi_nxt = rx_byte;
            idx_nxt    = idx_r + IDX_W'(1);
          end else begin
            // Last trailer byte: close the frame and check the sum.
            phase_nxt      = PH_HUNT;
            hc_nxt         = '0;
            idx_nxt        = '0;
            sum_nxt        = '0;
            res.has_result = 1'b1;
            if ({trl_hi_r, rx_byte} == sum_r) begin
              res.status     = ST_OK;
              res.pm1_value  = pm_r[0];
              res.pm25_value = pm_r[1];
              res.pm10_value = pm_r[2];
            end else begin
              res.status = ST_CSUM_ERR;
            end
          end
        end
        default: begin
          if (action == ACT_TIMEOUT) begin
            if (phase_r == PH_GOT42) begin
              // Drop the lone header byte; keep the hunt count.
              phase_nxt = PH_HUNT;
            end else begin
              phase_nxt      = PH_HUNT;
              hc_nxt         = '0;
              idx_nxt        = '0;
              sum_nxt        = '0;
              res.has_result = 1'b1;
              res.status     = ST_TIMEOUT;
            end
          end else if (phase_r == PH_GOT42 && rx_byte == PSPAR_HDR_SECOND) begin
            phase_nxt = PH_BODY;
            hc_nxt    = '0;
            idx_nxt   = IDX_START;
            sum_nxt   = PSPAR_HDR_SUM;
          end else begin
            hc_nxt    = hc_inc;
            phase_nxt = (rx_byte == PSPAR_HDR_FIRST) ? PH_GOT42 : PH_HUNT;
            if (hc_inc >= HUNT_LIMIT) begin
              phase_nxt      = PH_HUNT;
              hc_nxt         = '0;
              idx_nxt        = '0;
              sum_nxt        = '0;
              res.has_result = 1'b1;
              res.status     = ST_NO_HEADER;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HUNT;
      idx_r    <= '0;
      hc_r     <= '0;
      sum_r    <= '0;
      trl_hi_r <= '0;
      for (int i = 0; i < 3; i++) begin
        pm_r[i] <= '0;
      end
    end else begin
      phase_r  <= phase_nxt;
      idx_r    <= idx_nxt;
      hc_r     <= hc_nxt;
      sum_r    <= sum_nxt;
      trl_hi_r <= trl_hi_nxt;
      pm_r     <= pm_nxt;
    end
  end

endmodule

/* rtl/core/particle_sensor_frame_parser.sv */
// An accepted word passes from the input register through the parser core into the result register.
// Throughput: one word per cycle, sustained; the input register, the parser core
// and the result register each advance every cycle unless the result sink stalls.
// Reset (rst_n low, synchronous): return to the header hunt with count, index, sum,
// trailer and captured readings cleared, and empty both registers.
// Depends on pspar_pkg, pspar_in_if, pspar_out_if and pspar_core.
module particle_sensor_frame_parser
  import pspar_pkg::*;
#(
  parameter int FRAME_LEN = PSPAR_FRAME_LEN
) (
  input  logic        clk,
  input  logic        rst_n,
  pspar_in_if.sink    in_chan,
  pspar_out_if.source out_chan
);

  // Input register: holds one word until the core may consume it.
  logic          stg_valid_r;
  pspar_action_t stg_action_r;
  logic [7:0]    stg_byte_r;

  // Result register.
  logic          out_valid_r;
  pspar_status_t out_status_r;
  logic [15:0]   out_pm1_r;
  logic [15:0]   out_pm25_r;
  logic [15:0]   out_pm10_r;

  logic          advance;    // result register may take a new value
  logic          consume;    // core consumes the staged word this cycle
  logic          in_fire;
  pspar_result_t core_res;

  // The result register frees up when empty or when its word is taken, so the
  // staged word can move on while the sink drains the previous result.
  assign advance       = !out_valid_r || out_chan.ready;
  assign consume       = stg_valid_r && advance;
  assign in_chan.ready = !stg_valid_r || advance;
  assign in_fire       = in_chan.valid && in_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else if (in_fire) begin
      stg_valid_r <= 1'b1;
    end else if (consume) begin
      stg_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      stg_action_r <= in_chan.action;
      stg_byte_r   <= in_chan.rx_byte;
    end
  end

  // Parser state advances only when the staged word is consumed.
  pspar_core #(
    .FRAME_LEN (FRAME_LEN)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (consume),
    .action  (stg_action_r),
    .rx_byte (stg_byte_r),
    .res     (core_res)
  );

  // Load the result register only for words that produce a result; most bytes
  // just advance the parser and leave the output empty.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= consume && core_res.has_result;
    end
  end

  always_ff @(posedge clk) begin
    if (consume && core_res.has_result && advance) begin
      out_status_r <= core_res.status;
      out_pm1_r    <= core_res.pm1_value;
      out_pm25_r   <= core_res.pm25_value;
      out_pm10_r   <= core_res.pm10_value;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.status     = out_status_r;
  assign out_chan.pm1_value  = out_pm1_r;
  assign out_chan.pm25_value = out_pm25_r;
  assign out_chan.pm10_value = out_pm10_r;

endmodule

/* rtl/core/pspar_checker.sv */
// Port-level checks for the particle sensor frame parser, bound to the top level.
// Depends on pspar_pkg and particle_sensor_frame_parser.
module pspar_checker
  import pspar_pkg::*;
(
  input logic          clk,
  input logic          rst_n,
  input logic          out_valid,
  input logic          out_ready,
  input pspar_status_t out_status,
  input logic [15:0]   out_pm1,
  input logic [15:0]   out_pm25,
  input logic [15:0]   out_pm10
);

  // Hold a stalled result word.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_pm1)
      && $stable(out_pm25) && $stable(out_pm10))
    else $error("result word changed while stalled");

  // Readings are zero on every non-ok result.
  a_zero_pm: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_pm1 == 16'd0 && out_pm25 == 16'd0
      && out_pm10 == 16'd0)
    else $error("nonzero reading on a failed frame");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind particle_sensor_frame_parser pspar_checker u_pspar_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_chan.valid),
  .out_ready  (out_chan.ready),
  .out_status (out_chan.status),
  .out_pm1    (out_chan.pm1_value),
  .out_pm25   (out_chan.pm25_value),
  .out_pm10   (out_chan.pm10_value)
);

/* dv/tb_particle_sensor_frame_parser.sv */
`timescale 1ns / 1ps
// Self-checking testbench for particle_sensor_frame_parser: drives bytes and timeouts,
// predicts every status/reading word and compares it with what the block returns.
// Depends on pspar_pkg, pspar_in_if, pspar_out_if and the parser RTL.
module tb_particle_sensor_frame_parser;
  import pspar_pkg::*;

  localparam int FRAME_LEN   = PSPAR_FRAME_LEN;
  localparam int PIPE_DEPTH  = 2;       // accept edge to result edge
  localparam int DRAIN_WAIT  = 8 * PIPE_DEPTH;
  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_PRINTED = 40;

  // One result word as the block reports it.
  typedef struct packed {
    pspar_status_t status;
    logic [15:0]   pm1;
    logic [15:0]   pm25;
    logic [15:0]   pm10;
  } sensor_report_t;

  // Frame parser predictor plus the queue of reports it still owes.
  class frame_tracker;
    pspar_phase_t   phase;
    logic [5:0]     body_idx;
    logic [6:0]     hunt_cnt;
    logic [15:0]    byte_sum;
    logic [7:0]     trailer_hi;
    logic [15:0]    pm_word [3];
    sensor_report_t owed_reports [$];
    int             error_count;
    int             reports_owed_total;
    int             reports_checked;
    int             words_noted;
    int             status_hits [4];

    function new();
      restart_hunt();
      trailer_hi = '0;
      foreach (pm_word[k]) pm_word[k] = '0;
      foreach (status_hits[k]) status_hits[k] = 0;
      error_count = 0;
      reports_owed_total = 0;
      reports_checked = 0;
      words_noted = 0;
    endfunction

    function void restart_hunt();
      phase    = PH_HUNT;
      hunt_cnt = '0;
      body_idx = '0;
      byte_sum = '0;
    endfunction

    function void owe_report(pspar_status_t st, logic [15:0] a, logic [15:0] b,
                             logic [15:0] c);
      sensor_report_t r;
      r.status = st;
      r.pm1    = a;
      r.pm25   = b;
      r.pm10   = c;
      owed_reports.push_back(r);
      reports_owed_total++;
    endfunction

    function int pending();
      return owed_reports.size();
    endfunction

    // Advance the predicted parser by one accepted input word.
    function void note_word(pspar_action_t act, logic [7:0] b);
      int  k;
      bit  sum_ok;
      words_noted++;
      if (phase == PH_BODY) begin
        if (act == ACT_TIMEOUT) begin
          restart_hunt();
          owe_report(ST_TIMEOUT, '0, '0, '0);
        end else if (body_idx < FRAME_LEN - 2) begin
          byte_sum = byte_sum + 16'(b);
          if (body_idx >= PSPAR_PM_FIRST_IDX && body_idx <= PSPAR_PM_LAST_IDX) begin
            k = (int'(body_idx) - PSPAR_PM_FIRST_IDX) / 2;
            pm_word[k] = {pm_word[k][7:0], b};
          end
          body_idx = body_idx + 6'd1;
        end else if (body_idx == FRAME_LEN - 2) begin
          trailer_hi = b;
          body_idx = body_idx + 6'd1;
        end else begin
          sum_ok = ({trailer_hi, b} == byte_sum);
          restart_hunt();
          if (sum_ok) owe_report(ST_OK, pm_word[0], pm_word[1], pm_word[2]);
          else owe_report(ST_CSUM_ERR, '0, '0, '0);
        end
        return;
      end
      // Hunting, with or without a lone first header byte.
      if (act == ACT_TIMEOUT) begin
        if (phase == PH_GOT42) begin
          phase = PH_HUNT;
        end else begin
          restart_hunt();
          owe_report(ST_TIMEOUT, '0, '0, '0);
        end
        return;
      end
      hunt_cnt = hunt_cnt + 7'd1;
      if (phase == PH_GOT42 && b == PSPAR_HDR_SECOND) begin
        phase    = PH_BODY;
        hunt_cnt = '0;
        body_idx = 6'(PSPAR_BODY_START);
        byte_sum = PSPAR_HDR_SUM;
        return;
      end
      if (b == PSPAR_HDR_FIRST) phase = PH_GOT42;
      else phase = PH_HUNT;
      if (hunt_cnt >= 2 * FRAME_LEN) begin
        restart_hunt();
        owe_report(ST_NO_HEADER, '0, '0, '0);
      end
    endfunction

    task report_mismatch(string line);
      error_count++;
      if (error_count <= MAX_PRINTED) $display("ERROR @%0t: %s", $time, line);
    endtask

    // Compare one returned word with the oldest report still owed.
    task check_report(pspar_status_t st, logic [15:0] a, logic [15:0] b, logic [15:0] c);
      sensor_report_t exp_r;
      if (owed_reports.size() == 0) begin
        report_mismatch($sformatf("result status %0d with no report owed", st));
        return;
      end
      exp_r = owed_reports.pop_front();
      reports_checked++;
      status_hits[exp_r.status]++;
      if (st !== exp_r.status)
        report_mismatch($sformatf("status got %0d want %0d", st, exp_r.status));
      if (a !== exp_r.pm1)
        report_mismatch($sformatf("pm1 got %h want %h", a, exp_r.pm1));
      if (b !== exp_r.pm25)
        report_mismatch($sformatf("pm25 got %h want %h", b, exp_r.pm25));
      if (c !== exp_r.pm10)
        report_mismatch($sformatf("pm10 got %h want %h", c, exp_r.pm10));
    endtask
  endclass

  logic clk;
  logic rst_n;

  pspar_in_if  in_chan ();
  pspar_out_if out_chan ();

  particle_sensor_frame_parser #(
    .FRAME_LEN(FRAME_LEN)
  ) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan)
  );

  frame_tracker tracker;

  int gap_pct;        // chance in 100 that the sender idles before a word
  int stall_pct;      // chance in 100 that the receiver drops ready on a cycle
  int hold_request;   // cycles of forced receiver hold-off, picked up by the receiver
  int words_sent;
  int cycle_count;

  logic [7:0] frame_buf [FRAME_LEN];

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Receiver: random stalls, or a long hold-off counted down here cycle by cycle.
  initial begin
    int hold_left;
    hold_left = 0;
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Feed every accepted input word to the predictor.
  always @(posedge clk) begin
    if (rst_n && in_chan.valid && in_chan.ready)
      tracker.note_word(in_chan.action, in_chan.rx_byte);
  end

  // Check every accepted result word against the oldest owed report.
  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready)
      tracker.check_report(out_chan.status, out_chan.pm1_value, out_chan.pm25_value,
                           out_chan.pm10_value);
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Watchdog expired after %0d cycles, %0d reports still owed",
               cycle_count, tracker.pending());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Byte with the extremes weighted up.
  function automatic logic [7:0] rand_byte();
    int r;
    r = $urandom_range(9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom_range(255));
  endfunction

  // Any byte except the first header byte, so the hunt count only climbs.
  function automatic logic [7:0] junk_byte();
    logic [7:0] v;
    v = rand_byte();
    while (v == PSPAR_HDR_FIRST) v = rand_byte();
    return v;
  endfunction

  // Offer one word; optionally idle first; return once it is accepted.
  task automatic send_word(pspar_action_t act, logic [7:0] val);
    while ($urandom_range(99) < gap_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid   <= 1'b1;
    in_chan.action  <= act;
    in_chan.rx_byte <= val;
    do @(posedge clk); while (!in_chan.ready);
    words_sent++;
  endtask

  // Hold the sender until every owed report has come back, then let the pipe settle.
  task automatic wait_drained();
    in_chan.valid <= 1'b0;
    while (tracker.pending() > 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // Build a frame in frame_buf. fill: 0 random readings, 1 all zero, 2 all ones.
  // A corrupt frame gets one bit flipped after the trailer is computed.
  task automatic fill_frame(int fill, bit corrupt);
    logic [15:0] sum;
    logic [15:0] reading;
    int          r;
    int          pos;
    frame_buf[0] = PSPAR_HDR_FIRST;
    frame_buf[1] = PSPAR_HDR_SECOND;
    for (int i = PSPAR_BODY_START; i < FRAME_LEN - 2; i++) frame_buf[i] = rand_byte();
    for (int k = 0; k < 3; k++) begin
      r = $urandom_range(9);
      if (fill == 1 || (fill == 0 && r < 2)) reading = 16'h0000;
      else if (fill == 2 || (fill == 0 && r < 4)) reading = 16'hFFFF;
      else reading = 16'($urandom_range(65535));
      frame_buf[PSPAR_PM_FIRST_IDX + 2 * k]     = reading[15:8];
      frame_buf[PSPAR_PM_FIRST_IDX + 2 * k + 1] = reading[7:0];
    end
    sum = '0;
    for (int i = 0; i < FRAME_LEN - 2; i++) sum = sum + 16'(frame_buf[i]);
    frame_buf[FRAME_LEN - 2] = sum[15:8];
    frame_buf[FRAME_LEN - 1] = sum[7:0];
    if (corrupt) begin
      pos = $urandom_range(PSPAR_BODY_START, FRAME_LEN - 1);
      frame_buf[pos] = frame_buf[pos] ^ 8'(1 << $urandom_range(7));
    end
  endtask

  // Send a frame, maybe behind extra first-header bytes or a little junk.
  // cut > 0 sends only the first cut bytes and then a receive timeout.
  task automatic send_frame(int fill, bit corrupt, int cut);
    int r;
    int last;
    r = $urandom_range(99);
    if (r < 15) begin
      repeat ($urandom_range(1, 2)) send_word(ACT_BYTE, PSPAR_HDR_FIRST);
    end else if (r < 25) begin
      repeat ($urandom_range(1, 3)) send_word(ACT_BYTE, rand_byte());
    end
    fill_frame(fill, corrupt);
    last = (cut > 0) ? cut : FRAME_LEN;
    for (int i = 0; i < last; i++) send_word(ACT_BYTE, frame_buf[i]);
    if (cut > 0) send_word(ACT_TIMEOUT, rand_byte());
  endtask

  // Two timeouts always leave the hunt at phase zero with a cleared count.
  task automatic clear_hunt();
    repeat (2) send_word(ACT_TIMEOUT, rand_byte());
  endtask

  // Run the hunt count to its limit. mode 0: plain exhaustion; mode 1: the
  // limit lands on a first header byte, so the next second byte is ignored;
  // mode 2: the header completes on the limit byte and a frame follows.
  task automatic exhaust_hunt(int mode);
    clear_hunt();
    case (mode)
      0: begin
        repeat (2 * FRAME_LEN) send_word(ACT_BYTE, junk_byte());
      end
      1: begin
        repeat (2 * FRAME_LEN - 1) send_word(ACT_BYTE, junk_byte());
        send_word(ACT_BYTE, PSPAR_HDR_FIRST);
        send_word(ACT_BYTE, PSPAR_HDR_SECOND);
      end
      default: begin
        repeat (2 * FRAME_LEN - 2) send_word(ACT_BYTE, junk_byte());
        fill_frame(0, 1'b0);
        for (int i = 0; i < FRAME_LEN; i++) send_word(ACT_BYTE, frame_buf[i]);
      end
    endcase
  endtask

  // Short burst of loose bytes, header fragments and timeouts.
  task automatic noise_burst();
    int r;
    repeat ($urandom_range(1, 12)) begin
      r = $urandom_range(99);
      if (r < 15) send_word(ACT_TIMEOUT, rand_byte());
      else if (r < 25) send_word(ACT_BYTE, PSPAR_HDR_FIRST);
      else if (r < 30) send_word(ACT_BYTE, PSPAR_HDR_SECOND);
      else send_word(ACT_BYTE, rand_byte());
    end
  endtask

  // Hand-picked words: timeouts in each hunt state, header rearm, a body timeout.
  task automatic run_directed();
    send_word(ACT_TIMEOUT, 8'hFF);             // timeout while hunting reports
    send_word(ACT_BYTE, 8'h00);
    send_word(ACT_BYTE, 8'hFF);
    send_word(ACT_BYTE, PSPAR_HDR_SECOND);     // second header byte alone does nothing
    send_word(ACT_BYTE, PSPAR_HDR_FIRST);
    send_word(ACT_TIMEOUT, 8'h00);             // lone first byte: silent restart
    send_word(ACT_TIMEOUT, 8'h5A);             // now a real hunt timeout
    send_word(ACT_BYTE, PSPAR_HDR_FIRST);
    send_word(ACT_BYTE, 8'h17);                // not a header: back to the hunt
    send_word(ACT_BYTE, PSPAR_HDR_FIRST);
    send_word(ACT_BYTE, PSPAR_HDR_FIRST);      // repeated first byte keeps the hunt armed
    send_word(ACT_BYTE, PSPAR_HDR_SECOND);     // header found
    send_word(ACT_BYTE, 8'hFF);
    send_word(ACT_BYTE, 8'h00);
    send_word(ACT_BYTE, 8'h80);
    send_word(ACT_TIMEOUT, 8'h00);             // timeout inside the body
    send_word(ACT_BYTE, PSPAR_HDR_FIRST);
    send_word(ACT_BYTE, PSPAR_HDR_SECOND);
    send_word(ACT_TIMEOUT, 8'hA5);             // timeout right after the header
  endtask

  // One idling setting; mix well-formed frames with damaged ones and noise
  // until enough words and reports have gone through.
  task automatic run_phase(int gap, int stall, int min_words, int min_reports);
    int w0;
    int r0;
    int r;
    gap_pct   = gap;
    stall_pct = stall;
    w0 = words_sent;
    r0 = tracker.reports_owed_total;
    while (words_sent - w0 < min_words || tracker.reports_owed_total - r0 < min_reports) begin
      r = $urandom_range(99);
      if (r < 45) send_frame(0, 1'b0, 0);
      else if (r < 60) send_frame(0, 1'b1, 0);
      else if (r < 70) send_frame(0, 1'b0, $urandom_range(2, FRAME_LEN - 1));
      else if (r < 78) exhaust_hunt($urandom_range(2));
      else noise_burst();
    end
  endtask

  initial begin
    tracker = new();
    gap_pct = 0;
    stall_pct = 0;
    hold_request = 0;
    words_sent = 0;
    cycle_count = 0;
    rst_n           <= 1'b0;
    in_chan.valid   <= 1'b0;
    in_chan.action  <= ACT_BYTE;
    in_chan.rx_byte <= 8'h00;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();

    // Receiver holds off for a long stretch while frames keep coming, so the
    // result register backs up and the input stalls. Then pause the sender
    // until every owed report is back.
    hold_request = 160;
    send_frame(1, 1'b0, 0);
    send_frame(2, 1'b0, 0);
    send_frame(0, 1'b0, 0);
    send_frame(0, 1'b1, 0);
    exhaust_hunt(2);
    wait_drained();

    run_phase(0, 0, 60, 2);
    run_phase(48, 0, 60, 2);
    run_phase(0, 48, 60, 2);
    run_phase(14, 14, 60, 2);

    wait_drained();

    $display("Sent %0d words (bytes and timeouts) through hunt, rearm, body and limit cases.",
             words_sent);
    $display("Checked %0d results: %0d ok, %0d checksum, %0d timeout, %0d no header.",
             tracker.reports_checked, tracker.status_hits[ST_OK],
             tracker.status_hits[ST_CSUM_ERR], tracker.status_hits[ST_TIMEOUT],
             tracker.status_hits[ST_NO_HEADER]);
    if (tracker.error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
